[hdl/ctp_pkg.sv]
package ctp_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int CORDIC_STAGES = 24;
    localparam int SQRT_STEPS    = 33;
    localparam int SAT_BITS      = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

    localparam logic signed [33:0] GAIN_INV  = 34'sd652032874;
    localparam logic [49:0]        ALPHA_EPS = 50'd4096;
    localparam logic [49:0]        ALPHA_ONE = 50'h1_0000_0000;

    typedef enum logic [2:0] {
        CFG_APEX    = 3'd0,
        CFG_AXIS    = 3'd1,
        CFG_RADIAL  = 3'd2,
        CFG_ANGULAR = 3'd3,
        CFG_RADII   = 3'd4,
        CFG_HEIGHT  = 3'd5,
        CFG_OFFSETS = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] point_u;
        logic signed [31:0] point_v;
    } point_t;

    typedef struct packed {
        logic               mapped;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } result_t;

    typedef struct packed {
        logic               valid;
        logic               mapped;
        logic               flip;
        logic signed [32:0] du;
        logic signed [32:0] dv;
        logic [32:0]        alpha;
        logic [33:0]        radius;
        logic signed [31:0] pz;
    } side_t;

    typedef struct packed {
        logic [65:0] rad;
        logic [34:0] rem;
        logic [32:0] root;
    } sqrt_t;

    typedef struct packed {
        logic signed [35:0] px;
        logic signed [35:0] py;
        logic [31:0]        pang;
        logic signed [35:0] qx;
        logic signed [35:0] qy;
        logic [31:0]        qang;
    } vec_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } rot_t;

    function automatic logic [31:0] atan_at(input logic [4:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            5'd31: a = 32'h00000000;
        endcase
        return a;
    endfunction

    function automatic logic signed [31:0] sat_out(input logic signed [36:0] v);
        logic signed [36:0] hi;
        logic signed [36:0] lo;
        logic signed [36:0] c;
        hi = (37'sd1 <<< (SAT_BITS - 1)) - 37'sd1;
        lo = -(37'sd1 <<< (SAT_BITS - 1));
        c  = v;
        if (v > hi)
            c = hi;
        else if (v < lo)
            c = lo;
        return c[31:0];
    endfunction

endpackage

[hdl/ctp_sqrt_cell.sv]
module ctp_sqrt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  ctp_pkg::side_t side_in,
    input  ctp_pkg::sqrt_t sq_in,
    output ctp_pkg::side_t side_out,
    output ctp_pkg::sqrt_t sq_out
);
    import ctp_pkg::*;

    side_t       side_reg;
    sqrt_t       sq_reg;
    sqrt_t       sq_next;
    logic [36:0] rem_sh;
    logic [36:0] trial;

    always_comb
    begin
        rem_sh      = {sq_in.rem, sq_in.rad[65:64]};
        trial       = {2'b00, sq_in.root, 2'b01};
        sq_next.rad = {sq_in.rad[63:0], 2'b00};
        if (rem_sh >= trial)
        begin
            sq_next.rem  = 35'(rem_sh - trial);
            sq_next.root = {sq_in.root[31:0], 1'b1};
        end
        else
        begin
            sq_next.rem  = rem_sh[34:0];
            sq_next.root = {sq_in.root[31:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else
            side_reg <= side_in;
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    assign side_out = side_reg;
    assign sq_out   = sq_reg;
endmodule

[hdl/ctp_vec_cell.sv]
module ctp_vec_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [4:0]     stage,
    input  ctp_pkg::side_t side_in,
    input  ctp_pkg::vec_t  vin,
    output ctp_pkg::side_t side_out,
    output ctp_pkg::vec_t  vout
);
    import ctp_pkg::*;

    side_t              side_reg;
    vec_t               v_reg;
    vec_t               v_next;
    logic signed [35:0] pxs, pys, qxs, qys;
    logic [31:0]        a;

    always_comb
    begin
        a   = atan_at(stage);
        pxs = vin.px >>> stage;
        pys = vin.py >>> stage;
        qxs = vin.qx >>> stage;
        qys = vin.qy >>> stage;
        if (vin.py > 36'sd0)
        begin
            v_next.px   = vin.px + pys;
            v_next.py   = vin.py - pxs;
            v_next.pang = vin.pang + a;
        end
        else
        begin
            v_next.px   = vin.px - pys;
            v_next.py   = vin.py + pxs;
            v_next.pang = vin.pang - a;
        end
        if (vin.qy > 36'sd0)
        begin
            v_next.qx   = vin.qx + qys;
            v_next.qy   = vin.qy - qxs;
            v_next.qang = vin.qang + a;
        end
        else
        begin
            v_next.qx   = vin.qx - qys;
            v_next.qy   = vin.qy + qxs;
            v_next.qang = vin.qang - a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else
            side_reg <= side_in;
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    assign side_out = side_reg;
    assign vout     = v_reg;
endmodule

[hdl/ctp_rot_cell.sv]
module ctp_rot_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [4:0]     stage,
    input  ctp_pkg::side_t side_in,
    input  ctp_pkg::rot_t  rin,
    output ctp_pkg::side_t side_out,
    output ctp_pkg::rot_t  rout
);
    import ctp_pkg::*;

    side_t              side_reg;
    rot_t               r_reg;
    rot_t               r_next;
    logic signed [33:0] xs, ys, a;

    always_comb
    begin
        a  = 34'(atan_at(stage));
        xs = rin.x >>> stage;
        ys = rin.y >>> stage;
        if (rin.z >= 34'sd0)
        begin
            r_next.x = rin.x - ys;
            r_next.y = rin.y + xs;
            r_next.z = rin.z - a;
        end
        else
        begin
            r_next.x = rin.x + ys;
            r_next.y = rin.y - xs;
            r_next.z = rin.z + a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else
            side_reg <= side_in;
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
    end

    assign side_out = side_reg;
    assign rout     = r_reg;
endmodule

[hdl/cone_texture_to_3d_point.sv]
// Cone texture to 3D point mapper. Fully pipelined: one point word is taken
// every cycle (busy never rises) and its result appears on result for
// exactly one cycle, flagged by done; the receiver cannot stall, so the
// result must be captured in that cycle. The pipeline is made of the
// 33-cell square root chain and the two 24-cell CORDIC chains (angle
// measurement, then sine/cosine) plus eleven multiply and setup stages.
// Registers are written through cfg_we/cfg_index/cfg_data only while the
// pipeline is empty (the user's duty; not enforced); index 7 is ignored.
module cone_texture_to_3d_point (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ctp_pkg::point_t  point,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [63:0]      cfg_data,
    output logic             done,
    output ctp_pkg::result_t result
);
    import ctp_pkg::*;

    logic [63:0] apex_reg, axis_reg, radial_reg, angular_reg, radii_reg, offsets_reg;
    logic [30:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apex_reg    <= '0;
            axis_reg    <= '0;
            radial_reg  <= '0;
            angular_reg <= '0;
            radii_reg   <= '0;
            height_reg  <= '0;
            offsets_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_APEX:    apex_reg    <= cfg_data;
                CFG_AXIS:    axis_reg    <= cfg_data;
                CFG_RADIAL:  radial_reg  <= cfg_data;
                CFG_ANGULAR: angular_reg <= cfg_data;
                CFG_RADII:   radii_reg   <= cfg_data;
                CFG_HEIGHT:  height_reg  <= cfg_data[30:0];
                CFG_OFFSETS: offsets_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign busy = 1'b0;

    // offsets from apex
    side_t s0_reg, s1_reg, s2_side, s0_next;
    logic [64:0] sqx_reg, sqy_reg;
    logic [32:0] ax, ay;

    always_comb
    begin
        s0_next       = '0;
        s0_next.valid = start;
        s0_next.du    = {point.point_u[31], point.point_u}
                        - {apex_reg[63], apex_reg[63:32]};
        s0_next.dv    = {point.point_v[31], point.point_v}
                        - {apex_reg[31], apex_reg[31:0]};
        ax = s0_reg.du[32] ? 33'(-s0_reg.du) : 33'(s0_reg.du);
        ay = s0_reg.dv[32] ? 33'(-s0_reg.dv) : 33'(s0_reg.dv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
        end
        else
        begin
            s0_reg <= s0_next;
            s1_reg <= s0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= 65'(66'(ax) * 66'(ax));
        sqy_reg <= 65'(66'(ay) * 66'(ay));
    end

    // square root chain
    side_t sq_side [0:SQRT_STEPS];
    sqrt_t sq_data [0:SQRT_STEPS];

    assign s2_side    = s1_reg;
    assign sq_side[0] = s2_side;
    assign sq_data[0] = '{rad: {1'b0, sqx_reg} + {1'b0, sqy_reg}, rem: '0, root: '0};

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        ctp_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .side_in  (sq_side[k]),
            .sq_in    (sq_data[k]),
            .side_out (sq_side[k+1]),
            .sq_out   (sq_data[k+1])
        );
    end

    // band position
    side_t s3_reg, s4_reg, s5_reg, s3_next, s5_next;
    logic signed [34:0] diff;
    logic [32:0]        ud_reg;
    logic [48:0]        p1_reg, p2_reg;
    logic [49:0]        alpha50;
    vec_t               v0_reg;

    assign diff = $signed({2'b00, sq_data[SQRT_STEPS].root})
                  - $signed({3'b000, radial_reg[63:32]});
    assign alpha50 = {1'b0, p1_reg} + 50'(p2_reg >> 16);

    always_comb
    begin
        s3_next        = sq_side[SQRT_STEPS];
        s3_next.mapped = (height_reg != '0) && !diff[34] && (diff != '0);
        s5_next        = s4_reg;
        s5_next.mapped = s4_reg.mapped && (alpha50 > ALPHA_EPS) && (alpha50 <= ALPHA_ONE);
        s5_next.alpha  = alpha50[32:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
            s4_reg <= '0;
            s5_reg <= '0;
        end
        else
        begin
            s3_reg <= s3_next;
            s4_reg <= s3_reg;
            s5_reg <= s5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ud_reg <= diff[32:0];
        p1_reg <= 49'(ud_reg * radial_reg[31:16]);
        p2_reg <= 49'(ud_reg * radial_reg[15:0]);
        if (s4_reg.du[32])
        begin
            v0_reg.px   <= 36'(-s4_reg.du);
            v0_reg.py   <= 36'(-s4_reg.dv);
            v0_reg.pang <= 32'h8000_0000;
        end
        else
        begin
            v0_reg.px   <= 36'(s4_reg.du);
            v0_reg.py   <= 36'(s4_reg.dv);
            v0_reg.pang <= '0;
        end
        if (axis_reg[63])
        begin
            v0_reg.qx   <= -36'($signed(axis_reg[63:32]));
            v0_reg.qy   <= -36'($signed(axis_reg[31:0]));
            v0_reg.qang <= 32'h8000_0000;
        end
        else
        begin
            v0_reg.qx   <= 36'($signed(axis_reg[63:32]));
            v0_reg.qy   <= 36'($signed(axis_reg[31:0]));
            v0_reg.qang <= '0;
        end
    end

    // angle measurement chain
    side_t vc_side [0:CORDIC_STAGES];
    vec_t  vc_data [0:CORDIC_STAGES];

    assign vc_side[0] = s5_reg;
    assign vc_data[0] = v0_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_vec
        ctp_vec_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .stage    (5'(i)),
            .side_in  (vc_side[i]),
            .vin      (vc_data[i]),
            .side_out (vc_side[i+1]),
            .vout     (vc_data[i+1])
        );
    end

    // theta, radius, height term
    side_t              v1_reg, v2_reg, v3_reg, v2_next, v3_next;
    logic [63:0]        prod_t_reg;
    logic [64:0]        prod_r_reg;
    logic signed [33:0] f_reg;
    logic [31:0]        ang;
    logic [31:0]        fmag;
    logic [31:0]        theta_reg;
    logic [30:0]        pm_reg;
    logic               fneg_reg;
    logic [31:0]        a_sh;
    logic [31:0]        a_fold;
    logic               flip;
    rot_t               r0_reg;

    assign ang    = vc_data[CORDIC_STAGES].qang - vc_data[CORDIC_STAGES].pang;
    assign fmag   = f_reg[33] ? 32'(-f_reg) : 32'(f_reg);
    assign a_sh   = theta_reg + 32'h4000_0000;
    assign flip   = a_sh[31];
    assign a_fold = flip ? theta_reg + 32'h8000_0000 : theta_reg;

    always_comb
    begin
        v2_next        = v1_reg;
        v2_next.radius = {1'b0, prod_r_reg[64:32]} + {2'b00, radii_reg[63:32]};
        v3_next        = v2_reg;
        v3_next.flip   = flip;
        v3_next.pz     = fneg_reg ? -$signed({1'b0, pm_reg}) : $signed({1'b0, pm_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= '0;
            v2_reg <= '0;
            v3_reg <= '0;
        end
        else
        begin
            v1_reg <= vc_side[CORDIC_STAGES];
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_t_reg <= 64'(ang) * 64'(angular_reg[63:32]);
        prod_r_reg <= 65'(vc_side[CORDIC_STAGES].alpha) * 65'(radii_reg[31:0]);
        f_reg      <= 34'sh0_8000_0000 - $signed({1'b0, vc_side[CORDIC_STAGES].alpha});

        theta_reg  <= prod_t_reg[47:16] + {angular_reg[29:0], 2'b00};
        pm_reg     <= 31'((63'(fmag) * 63'(height_reg)) >> 32);
        fneg_reg   <= f_reg[33];

        r0_reg.x   <= GAIN_INV;
        r0_reg.y   <= '0;
        r0_reg.z   <= 34'($signed(a_fold));
    end

    // sine/cosine chain
    side_t rc_side [0:CORDIC_STAGES];
    rot_t  rc_data [0:CORDIC_STAGES];

    assign rc_side[0] = v3_reg;
    assign rc_data[0] = r0_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_rot
        ctp_rot_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .stage    (5'(i)),
            .side_in  (rc_side[i]),
            .rin      (rc_data[i]),
            .side_out (rc_side[i+1]),
            .rout     (rc_data[i+1])
        );
    end

    // scale by radius, offsets, saturation
    side_t              e1_reg, e2_reg;
    logic [30:0]        mc_reg, ms_reg;
    logic               nc_reg, ns_reg, nc2_reg, ns2_reg;
    logic [34:0]        px_reg, py_reg;
    logic signed [33:0] cv, sv;
    logic [33:0]        cm, sm;
    logic signed [36:0] ox, oy, oz;
    logic               done_reg;
    result_t            res_reg;

    always_comb
    begin
        cv = rc_side[CORDIC_STAGES].flip ? -rc_data[CORDIC_STAGES].x
                                         : rc_data[CORDIC_STAGES].x;
        sv = rc_side[CORDIC_STAGES].flip ? -rc_data[CORDIC_STAGES].y
                                         : rc_data[CORDIC_STAGES].y;
        cm = cv[33] ? 34'(-cv) : 34'(cv);
        sm = sv[33] ? 34'(-sv) : 34'(sv);
        ox = nc2_reg ? -$signed({2'b00, px_reg}) : $signed({2'b00, px_reg});
        oy = (ns2_reg ? -$signed({2'b00, py_reg}) : $signed({2'b00, py_reg}))
             + 37'($signed(offsets_reg[63:32]));
        oz = 37'(e2_reg.pz) + 37'($signed(offsets_reg[31:0]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_reg   <= '0;
            e2_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            e1_reg   <= rc_side[CORDIC_STAGES];
            e2_reg   <= e1_reg;
            done_reg <= e2_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg  <= (cm > 34'h4000_0000) ? 31'h4000_0000 : cm[30:0];
        ms_reg  <= (sm > 34'h4000_0000) ? 31'h4000_0000 : sm[30:0];
        nc_reg  <= cv[33];
        ns_reg  <= sv[33];

        px_reg  <= 35'((65'(mc_reg) * 65'(e1_reg.radius)) >> 30);
        py_reg  <= 35'((65'(ms_reg) * 65'(e1_reg.radius)) >> 30);
        nc2_reg <= nc_reg;
        ns2_reg <= ns_reg;

        if (e2_reg.valid && e2_reg.mapped)
        begin
            res_reg.mapped <= 1'b1;
            res_reg.pos_x  <= sat_out(ox);
            res_reg.pos_y  <= sat_out(oy);
            res_reg.pos_z  <= sat_out(oz);
        end
        else
        begin
            res_reg <= '0;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_cone_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.mapped |-> height_reg != '0)
        else $error("mapped result with zero cone height");

    a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.mapped |-> result.pos_x == '0 && result.pos_y == '0
                                   && result.pos_z == '0)
        else $error("unmapped result carries nonzero position");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> !result.mapped)
        else $error("mapped flag set without done");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(e2_reg.valid))
        else $error("done without a word in the last stage");
endmodule

[sim/ctp_checker.sv]
module ctp_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  ctp_pkg::point_t  point,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [63:0]      cfg_data,
    input  logic             done,
    input  ctp_pkg::result_t result,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ctp_pkg::*;

    logic [63:0] apex_reg, axis_reg, radial_reg, angular_reg, radii_reg, offs_reg;
    logic [30:0] height_reg;
    result_t     expected_q[$];

    function automatic longint arsh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] arc_tab(int i);
        logic [31:0] t[32];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
              32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
              32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
              32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
              32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
              32'h00000001, 32'h00000000};
        return t[i];
    endfunction

    function automatic logic [32:0] int_sqrt(logic [65:0] v);
        logic [67:0] rem;
        logic [67:0] trial;
        logic [33:0] root;
        rem = 0;
        root = 0;
        for (int k = 32; k >= 0; k--)
        begin
            rem = (rem << 2) | 68'(v[2*k +: 2]);
            trial = 68'({root, 2'b01});
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = {root[32:0], 1'b1};
            end
            else
                root = {root[32:0], 1'b0};
        end
        return root[32:0];
    endfunction

    function automatic logic [31:0] polar_angle(longint x, longint y);
        logic [31:0] z;
        longint xs, ys;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            xs = arsh(x, i);
            ys = arsh(y, i);
            if (y > 0)
            begin
                x += ys; y -= xs; z += arc_tab(i);
            end
            else
            begin
                x -= ys; y += xs; z -= arc_tab(i);
            end
        end
        return z;
    endfunction

    function automatic void rotate(logic [31:0] a, output longint c, output longint s);
        logic   flip;
        longint x, y, z, xs, ys;
        logic [31:0] t;
        flip = 0;
        x = 652032874;
        y = 0;
        t = a + 32'h40000000;
        if (t[31])
        begin
            a = a + 32'h80000000;
            flip = 1;
        end
        z = longint'(signed'(a));
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            xs = arsh(x, i);
            ys = arsh(y, i);
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= longint'(arc_tab(i));
            end
            else
            begin
                x += ys; y -= xs; z += longint'(arc_tab(i));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint scale_trig(longint t, logic [63:0] r);
        logic [63:0] m;
        logic [63:0] p;
        m = t < 0 ? 64'(-t) : 64'(t);
        if (m > 64'h40000000)
            m = 64'h40000000;
        p = (m * r) >> 30;
        return t < 0 ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sh7FFFFFFF)
            v = 64'sh7FFFFFFF;
        if (v < -64'sh80000000)
            v = -64'sh80000000;
        return v[31:0];
    endfunction

    function automatic result_t map_point(point_t p);
        result_t     res;
        longint      du, dv, diff, c, s, f, pz;
        logic [63:0] ax, ay, sqx, sqy, lo, inv, ud, alpha, radius, pm;
        logic [31:0] ang, theta;
        res = '0;
        du = longint'(p.point_u) - longint'(signed'(apex_reg[63:32]));
        dv = longint'(p.point_v) - longint'(signed'(apex_reg[31:0]));
        ax = du < 0 ? 64'(-du) : 64'(du);
        ay = dv < 0 ? 64'(-dv) : 64'(dv);
        sqx = ax * ax;
        sqy = ay * ay;
        lo = sqx + sqy;
        diff = longint'(int_sqrt({1'b0, lo < sqx, lo})) - longint'(radial_reg[63:32]);
        if (height_reg == 0 || diff <= 0)
            return res;
        ud = 64'(diff);
        inv = {32'd0, radial_reg[31:0]};
        alpha = ud * (inv >> 16) + ((ud * (inv & 64'hFFFF)) >> 16);
        if (alpha <= 64'd4096 || alpha > 64'h1_0000_0000)
            return res;
        ang = polar_angle(longint'(signed'(axis_reg[63:32])), longint'(signed'(axis_reg[31:0])))
            - polar_angle(du, dv);
        theta = 32'((64'(ang) * 64'(angular_reg[63:32])) >> 16) + (angular_reg[31:0] << 2);
        rotate(theta, c, s);
        radius = ((alpha * 64'(radii_reg[31:0])) >> 32) + 64'(radii_reg[63:32]);
        f = 64'sh80000000 - longint'(alpha);
        pm = ((f < 0 ? 64'(-f) : 64'(f)) * 64'(height_reg)) >> 32;
        pz = f < 0 ? -longint'(pm) : longint'(pm);
        res.mapped = 1'b1;
        res.pos_x = clip32(scale_trig(c, radius));
        res.pos_y = clip32(scale_trig(s, radius) + longint'(signed'(offs_reg[63:32])));
        res.pos_z = clip32(pz + longint'(signed'(offs_reg[31:0])));
        return res;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            apex_reg    <= '0;
            axis_reg    <= '0;
            radial_reg  <= '0;
            angular_reg <= '0;
            radii_reg   <= '0;
            height_reg  <= '0;
            offs_reg    <= '0;
            fail_count  <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_APEX:    apex_reg    <= cfg_data;
                    CFG_AXIS:    axis_reg    <= cfg_data;
                    CFG_RADIAL:  radial_reg  <= cfg_data;
                    CFG_ANGULAR: angular_reg <= cfg_data;
                    CFG_RADII:   radii_reg   <= cfg_data;
                    CFG_HEIGHT:  height_reg  <= cfg_data[30:0];
                    CFG_OFFSETS: offs_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_q.push_back(map_point(point));
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want !== result)
                    begin
                        $display({"%0t: mismatch expected m=%0b x=%h y=%h z=%h",
                                  " got m=%0b x=%h y=%h z=%h"},
                                 $time, want.mapped, want.pos_x, want.pos_y, want.pos_z,
                                 result.mapped, result.pos_x, result.pos_y, result.pos_z);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[sim/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ctp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    point_t      point;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        done;
    result_t     result;
    int          fail_count;
    int          pending;

    cone_texture_to_3d_point u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point     (point),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    ctp_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (110) @(posedge clk);
    endtask

    // word sent, with random gaps unless calm
    task automatic send_point(logic [31:0] u, logic [31:0] v, bit calm);
        while (!calm && $urandom_range(99) < 19)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        point <= '{point_u: u, point_v: v};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_start();
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'(signed'(($urandom_range(2000000) - 1000000) * 64));
        endcase
    endfunction

    // a sane cone: apex at a, inner length L, band width W pixels
    task automatic sane_cone(logic [31:0] ax, logic [31:0] ay);
        logic [31:0] inner, width;
        inner = 32'($urandom_range(20, 200)) << 16;
        width = 32'($urandom_range(10, 200));
        write_reg(CFG_APEX, {ax, ay});
        write_reg(CFG_AXIS, {32'($urandom_range(2000000000)) - 32'd1000000000,
                             32'($urandom_range(2000000000)) - 32'd1000000000});
        write_reg(CFG_RADIAL, {inner, 32'((64'h1_0000_0000 / width) >> 16)});
        write_reg(CFG_ANGULAR, {32'($urandom_range(1 << 17)), $urandom});
        write_reg(CFG_RADII, {32'($urandom_range(1 << 24)), 32'($urandom_range(1 << 24))});
        write_reg(CFG_HEIGHT, 64'($urandom_range(1, 32'h7FFFFFFF)));
        write_reg(CFG_OFFSETS, {$urandom, $urandom});
    endtask

    task automatic band_point(logic [31:0] ax, logic [31:0] ay, bit calm);
        int   r;
        int   a;
        real  ang;
        r = $urandom_range(10, 420) << 16;
        ang = $urandom_range(0, 6283) / 1000.0;
        a = $rtoi(r * $cos(ang));
        send_point(ax + 32'(a), ay + 32'($rtoi(r * $sin(ang))), calm);
    endtask

    initial
    begin
        logic [31:0] ax, ay;
        bit          calm;
        start     = 0;
        point     = '0;
        cfg_we    = 0;
        cfg_index = CFG_APEX;
        cfg_data  = '0;
        rst_n     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // invalid cone from reset, then extremes
        send_point(32'h7FFFFFFF, 32'h80000000, 1);
        send_point(32'h80000000, 32'h7FFFFFFF, 1);
        idle_start();
        drain();
        write_reg(CFG_APEX, 64'h7FFFFFFF_7FFFFFFF);
        write_reg(CFG_AXIS, 64'h0);
        write_reg(CFG_RADIAL, 64'h00000000_FFFFFFFF);
        write_reg(CFG_ANGULAR, 64'hFFFFFFFF_FFFFFFFF);
        write_reg(CFG_RADII, 64'hFFFFFFFF_FFFFFFFF);
        write_reg(CFG_HEIGHT, 64'h7FFFFFFF);
        write_reg(CFG_OFFSETS, 64'h7FFFFFFF_80000000);
        write_reg(cfg_idx_t'(3'd7), 64'hFFFF);
        send_point(32'h80000000, 32'h80000000, 1);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 1);
        send_point(32'h7FFF0000, 32'h7FFFFFFF, 0);
        send_point(32'h7FFFFFFF, 32'h7FFEFFFF, 0);
        send_point(32'h0, 32'h0, 0);
        idle_start();
        drain();
        write_reg(CFG_APEX, 64'h80000000_80000000);
        write_reg(CFG_RADIAL, 64'h0000000A_00000000);
        send_point(32'h80000000, 32'h80001000, 1);
        idle_start();
        drain();
        write_reg(CFG_RADIAL, 64'hFFFFFFFF_00010000);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 1);
        idle_start();
        drain();
        sane_cone(0, 0);
        for (int i = 0; i < 12; i++)
            band_point(0, 0, 1);
        idle_start();
        drain();

        // random phases
        for (int ph = 0; ph < 8; ph++)
        begin
            ax = rand_word() >>> 2;
            ay = rand_word() >>> 2;
            sane_cone(ax, ay);
            if (ph == 7)
                write_reg(CFG_HEIGHT, 64'h0);
            calm = (ph == 3);
            for (int i = 0; i < 60; i++)
            begin
                if ($urandom_range(9) < 8)
                    band_point(ax, ay, calm);
                else
                    send_point(rand_word(), rand_word(), calm);
            end
            idle_start();
            drain();
        end
        // noise under random registers
        write_reg(CFG_APEX, {$urandom, $urandom});
        write_reg(CFG_RADIAL, {$urandom, $urandom});
        write_reg(CFG_AXIS, {$urandom, $urandom});
        for (int i = 0; i < 40; i++)
            send_point(rand_word(), rand_word(), 0);
        idle_start();
        drain();

        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
